// ----- rtl/base64_stream_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// shared property wrappers clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define B64E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define B64E_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define B64E_ASSERT(lbl, prop, msg)

`define B64E_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- rtl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// types, constants and the alphabet lookup for the base64 stream encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int          QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] CAP_RESET       = 16'd256;
  localparam logic [7:0]  PAD_CHAR        = 8'h3D;

  // one request worth of output characters, slot 0 first
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [3:0]      lasts;
    logic [3:0]      ovfs;
    logic [2:0]      cnt;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      b64_char = 8'h41 + v;
    end else if (s < 6'd52) begin
      b64_char = 8'h61 + v - 8'd26;
    end else if (s < 6'd62) begin
      b64_char = 8'h30 + v - 8'd52;
    end else if (s == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// accepts message bytes, tracks group state and capacity, builds char entries
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_fire,
  input  logic [7:0]     data_byte,
  input  logic           byte_valid,
  input  logic           msg_last,
  output b64e_pkg::push_t push_o
);
  import b64e_pkg::*;

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  logic [15:0] cap_r;
  logic [3:0]  carry_r, carry_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic        drop_r, drop_nxt;

  logic [3:0][7:0] pend;
  logic [2:0]      n;
  logic [1:0]      ph;
  logic [3:0]      cb;
  logic            stop;
  logic            fin;
  logic [16:0]     need;
  entry_t          ent;

  always_comb begin
    pend = '0;
    n    = '0;
    cb   = carry_r;
    ph   = (phase_r == 2'd3) ? PH0 : phase_r;
    if (byte_valid) begin
      unique case (ph)
        PH0: begin
          pend[0] = b64_char(data_byte[7:2]);
          cb = {2'b00, data_byte[1:0]};
          ph = PH1;
          n  = 3'd1;
        end
        PH1: begin
          pend[0] = b64_char({carry_r[1:0], data_byte[7:4]});
          cb = data_byte[3:0];
          ph = PH2;
          n  = 3'd1;
        end
        default: begin
          pend[0] = b64_char({carry_r, data_byte[7:6]});
          pend[1] = b64_char(data_byte[5:0]);
          cb = '0;
          ph = PH0;
          n  = 3'd2;
        end
      endcase
    end
    if (msg_last) begin
      if (ph == PH1) begin
        pend[n[1:0]]        = b64_char({cb[1:0], 4'b0000});
        pend[n[1:0] + 2'd1] = PAD_CHAR;
        pend[n[1:0] + 2'd2] = PAD_CHAR;
        n = n + 3'd3;
      end else if (ph == PH2) begin
        pend[n[1:0]]        = b64_char({cb, 2'b00});
        pend[n[1:0] + 2'd1] = PAD_CHAR;
        n = n + 3'd2;
      end
      ph = PH0;
    end
  end

  always_comb begin
    ent       = '0;
    stop      = 1'b0;
    fin       = 1'b0;
    need      = '0;
    carry_nxt = carry_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (drop_r) begin
      if (msg_last) begin
        carry_nxt = '0;
        phase_nxt = PH0;
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (!stop && (3'(i) < n)) begin
          fin  = msg_last && (3'(i) == n - 3'd1);
          need = {1'b0, count_r} + 17'(i) + {16'd0, fin};
          ent.cnt = 3'(i + 1);
          if (need >= {1'b0, cap_r}) begin
            ent.lasts[i] = 1'b1;
            ent.ovfs[i]  = 1'b1;
            stop = 1'b1;
          end else begin
            ent.chars[i] = pend[i];
            ent.lasts[i] = fin;
          end
        end
      end
      if (msg_last && (n == 3'd0) && (count_r >= cap_r)) begin
        ent.cnt      = 3'd1;
        ent.lasts[0] = 1'b1;
        ent.ovfs[0]  = 1'b1;
      end
      if (msg_last) begin
        carry_nxt = '0;
        phase_nxt = PH0;
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end else if (stop) begin
        carry_nxt = '0;
        phase_nxt = PH0;
        drop_nxt  = 1'b1;
      end else begin
        carry_nxt = cb;
        phase_nxt = ph;
        count_nxt = count_r + {13'd0, n};
      end
    end
  end

  assign push_o.push  = in_fire && (ent.cnt != 3'd0);
  assign push_o.entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      carry_r <= '0;
      phase_r <= PH0;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_fire) begin
        carry_r <= carry_nxt;
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

endmodule

// ----- rtl/b64e_queue.sv -----
// ----------------------------------------------------------------------------
// b64e_queue
// short fifo of character entries between front and back
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  b64e_pkg::push_t push_i,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output b64e_pkg::entry_t head
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_i.push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push_i.push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `B64E_ASSERT_NEVER(a_q_pop_empty, pop && !head_valid, "queue popped while empty")
  `B64E_ASSERT_NEVER(a_q_push_full, push_i.push && full, "queue pushed while full")
  `B64E_ASSERT(a_q_count_range, count_r <= FULL_CNT, "queue count beyond depth")

endmodule

// ----- rtl/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// walks the head entry one character per cycle into the output register, while out_tready allows
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  b64e_pkg::entry_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);
  import b64e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r, ovf_r;
  logic       load;
  logic       at_end;

  assign load   = head_valid && (!valid_r || out_tready);
  assign at_end = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.chars[idx_r];
      last_r <= head.lasts[idx_r];
      ovf_r  <= head.ovfs[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = ovf_r;

  `B64E_ASSERT(a_idx_range, head_valid |-> ({1'b0, idx_r} < head.cnt),
               "character index past entry count")
  `B64E_ASSERT(a_ovf_ends, (valid_r && ovf_r) |-> (last_r && data_r == 8'd0),
               "overflow request not marked final")
  `B64E_ASSERT(a_idx_rewind, $past(pop) |-> (idx_r == 2'd0),
               "index not rewound after entry done")

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder with output capacity check and overflow abort
// ----------------------------------------------------------------------------
// Bytes enter one per request and standard base64 characters leave one per
// cycle while out_tready allows, with '=' padding on the request marked tlast.
// An input request is accepted whenever the entry queue (QUEUE_DEPTH entries)
// has room, so new requests can be taken while earlier characters still
// leave; each request yields zero to four characters. A request with tuser
// low and tlast high ends a message without a byte. When the cfg_wdata
// capacity (one slot kept for a terminator) would be exceeded, one character
// with tuser and tlast high and tdata zero ends the message and its remaining
// bytes are dropped. Write the capacity only while the block is idle.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // out_capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte
  input  logic        in_tuser,    // byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // char_code
  output logic        out_tuser,   // overflow
  output logic        out_tlast
);
  import b64e_pkg::*;

  push_t  push;
  entry_t head;
  logic   full;
  logic   head_valid;
  logic   pop;
  logic   in_fire;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .data_byte  (in_tdata),
    .byte_valid (in_tuser),
    .msg_last   (in_tlast),
    .push_o     (push)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// base64 stream encoder testbench
// feeds byte messages through the encoder and compares every emitted
// character, last mark and overflow flag against a cycle-free model of the
// encoder, across several output capacities with random idling on both sides
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [7:0] code;
  logic       last;
  logic       ovf;
} b64_char_t;

class base64_char_tracker;
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [15:0] capacity;
  logic [3:0]  carry;
  logic [1:0]  phase;
  logic [15:0] emitted;
  logic        dropping;
  b64_char_t   pending_chars[$];
  int          errors;
  int          chars_checked;
  int          overflows_seen;
  int          requests_seen;

  function new();
    capacity       = b64e_pkg::CAP_RESET;
    errors         = 0;
    chars_checked  = 0;
    overflows_seen = 0;
    requests_seen  = 0;
    clear_message();
  endfunction

  function void clear_message();
    carry    = 4'd0;
    phase    = 2'd0;
    emitted  = 16'd0;
    dropping = 1'b0;
  endfunction

  function logic [7:0] sextet_char(logic [5:0] s);
    return ALPHABET[8*(63 - int'(s)) +: 8];
  endfunction

  function void push_char(logic [7:0] code, logic last, logic ovf);
    b64_char_t c;
    c.code = code;
    c.last = last;
    c.ovf  = ovf;
    pending_chars.push_back(c);
  endfunction

  function void encode_request(logic [7:0] data_b, logic has_byte, logic msg_end);
    logic [7:0]  pend [4];
    int          n;
    logic        fin;
    int unsigned need;
    logic [1:0]  ph;
    n = 0;
    requests_seen++;
    if (dropping) begin
      if (msg_end) clear_message();
      return;
    end
    ph = (phase == 2'd3) ? 2'd0 : phase;
    if (has_byte) begin
      if (ph == 2'd0) begin
        pend[n++] = sextet_char(data_b[7:2]);
        carry = {2'b00, data_b[1:0]};
        ph = 2'd1;
      end else if (ph == 2'd1) begin
        pend[n++] = sextet_char({carry[1:0], data_b[7:4]});
        carry = data_b[3:0];
        ph = 2'd2;
      end else begin
        pend[n++] = sextet_char({carry, data_b[7:6]});
        pend[n++] = sextet_char(data_b[5:0]);
        carry = 4'd0;
        ph = 2'd0;
      end
    end
    if (msg_end) begin
      if (ph == 2'd1) begin
        pend[n++] = sextet_char({carry[1:0], 4'd0});
        pend[n++] = b64e_pkg::PAD_CHAR;
        pend[n++] = b64e_pkg::PAD_CHAR;
      end else if (ph == 2'd2) begin
        pend[n++] = sextet_char({carry, 2'd0});
        pend[n++] = b64e_pkg::PAD_CHAR;
      end
      ph = 2'd0;
    end
    phase = ph;
    for (int i = 0; i < n; i++) begin
      fin  = msg_end && (i == n - 1);
      need = int'(emitted) + (fin ? 1 : 0);
      if (need >= int'(capacity)) begin
        push_char(8'd0, 1'b1, 1'b1);
        if (msg_end) begin
          clear_message();
        end else begin
          dropping = 1'b1;
          carry    = 4'd0;
          phase    = 2'd0;
        end
        return;
      end
      push_char(pend[i], fin, 1'b0);
      emitted = emitted + 16'd1;
    end
    if (msg_end) begin
      if (n == 0 && emitted >= capacity) push_char(8'd0, 1'b1, 1'b1);
      clear_message();
    end
  endfunction

  function void check_char(logic [7:0] code, logic last, logic ovf);
    b64_char_t exp_c;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected character code %h last %b overflow %b",
               $time, code, last, ovf);
      errors++;
      return;
    end
    exp_c = pending_chars.pop_front();
    chars_checked++;
    if (ovf) overflows_seen++;
    if (code !== exp_c.code) begin
      $display("%0t: char_code expected %h actual %h", $time, exp_c.code, code);
      errors++;
    end
    if (last !== exp_c.last) begin
      $display("%0t: run_last expected %b actual %b", $time, exp_c.last, last);
      errors++;
    end
    if (ovf !== exp_c.ovf) begin
      $display("%0t: overflow expected %b actual %b", $time, exp_c.ovf, ovf);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending_chars.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 12;
  localparam int RANDOM_ITEMS = 80;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = 16'd0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  base64_char_tracker tracker = new();
  int  cycles       = 0;
  int  hold_order   = 0;
  int  cap_settings = 0;
  int  random_sent  = 0;
  bit  quiet        = 1'b0;

  base64_stream_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: check accepted characters, then pick the next tready
  initial begin
    int stall_left;
    int hold_done;
    int g;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.check_char(out_tdata, out_tlast, out_tuser);
      if (hold_done != hold_order) begin
        hold_done  = hold_order;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        g = rst_n ? idle_len() : 0;
        if (g > 0) begin
          stall_left = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(logic [7:0] data_b, logic has_byte, logic msg_end);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data_b;
    in_tuser  <= has_byte;
    in_tlast  <= msg_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.encode_request(data_b, has_byte, msg_end);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.capacity = value;
    cap_settings++;
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(int len, bit end_on_byte, bit count_it);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      if (count_it) random_sent++;
    end
    if (!end_on_byte || len == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      if (count_it) random_sent++;
    end
  endtask

  initial begin
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty message, idle, every flush shape
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h4D, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFB, 1'b1, 1'b0);
    send_item(8'hEF, 1'b1, 1'b0);
    send_item(8'hBE, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h34, 1'b1, 1'b1);

    // zero capacity: immediate overflow, terminator-only overflow, dropping
    write_capacity(16'd0);
    send_item(8'h41, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h42, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // capacity four: terminator check on a group boundary and on padding
    write_capacity(16'd4);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h4D, 1'b1, 1'b1);

    // largest capacity, long message against a long receiver hold-off
    write_capacity(16'hFFFF);
    hold_order++;
    send_message(30, 1'b1, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9)) inside
        [0:4]:   write_capacity(16'($urandom_range(64, 65535)));
        [5:7]:   write_capacity(16'($urandom_range(1, 12)));
        default: write_capacity(16'($urandom));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
        send_message(len, $urandom_range(0, 9) < 7, 1'b1);
      end
      quiet = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d input requests over %0d capacity settings", tracker.requests_seen,
             cap_settings);
    $display("checked %0d characters, %0d of them overflow marks", tracker.chars_checked,
             tracker.overflows_seen);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
